// File: rtl/rgbfd_pkg.sv
package rgbfd_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ONOFF = 2'd1,
        CMD_LEVEL = 2'd2,
        CMD_COLOR = 2'd3
    } cmd_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_SENSOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT  = 2'd2;

    localparam logic [9:0]  STEP_INTERVAL_RST = 10'd10;
    localparam logic [15:0] INIT_TIMEOUT_RST  = 16'd10000;
    localparam logic [23:0] COLOR_WHITE       = 24'hFFFFFF;

    localparam int          LEVEL_MAX_INT = 100;
    localparam logic [6:0]  LEVEL_MAX     = 7'd100;

    localparam logic [2:0] INIT_ON    = 3'b001;
    localparam logic [2:0] INIT_LEVEL = 3'b010;
    localparam logic [2:0] INIT_COLOR = 3'b100;
    localparam logic [2:0] INIT_ALL   = 3'b111;

    // duty = (channel * RECIP[brightness]) >> RECIP_SHIFT equals channel * brightness / 100
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP_W     = 16;
    localparam int RECIP_DEPTH = 128;

    typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_DEPTH];

    function automatic recip_tab_t build_recip();
        recip_tab_t t;
        for (int b = 0; b < RECIP_DEPTH; b++)
        begin
            t[b] = RECIP_W'((b * (1 << RECIP_SHIFT) + LEVEL_MAX_INT - 1) / LEVEL_MAX_INT);
        end
        return t;
    endfunction

    localparam recip_tab_t RECIP = build_recip();

endpackage

// File: rtl/rgbfd_if.sv
interface rgbfd_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [31:0]        now_ms;
    logic [7:0]         target_sensor;
    logic signed [15:0] level_value;
    logic [23:0]        color_value;

    modport source (output valid, cmd, now_ms, target_sensor, level_value, color_value,
                    input ready);
    modport sink (input valid, cmd, now_ms, target_sensor, level_value, color_value,
                  output ready);
endinterface

interface rgbfd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_duty;
    logic [7:0]  green_duty;
    logic [7:0]  blue_duty;
    logic        request_state;
    logic        report_color_valid;
    logic        report_on_valid;
    logic        report_level_valid;
    logic [23:0] report_color;
    logic        report_on;
    logic [6:0]  report_level;

    modport source (output valid, red_duty, green_duty, blue_duty, request_state,
                    report_color_valid, report_on_valid, report_level_valid,
                    report_color, report_on, report_level,
                    input ready);
    modport sink (input valid, red_duty, green_duty, blue_duty, request_state,
                  report_color_valid, report_on_valid, report_level_valid,
                  report_color, report_on, report_level,
                  output ready);
endinterface

// File: rtl/rgbfd_scale.sv
module rgbfd_scale (
    input  logic [23:0]                   color,
    input  logic [rgbfd_pkg::RECIP_W-1:0] recip,
    output logic [23:0]                   duty
);

    logic [rgbfd_pkg::RECIP_W+7:0] prod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = color[i*8 +: 8] * recip;
            duty[i*8 +: 8] = prod[i][rgbfd_pkg::RECIP_SHIFT +: 8];
        end
    end

endmodule

// File: rtl/rgb_led_fading_dimmer_top.sv
// channel   role     handshake      payload
// cmd_in    sink     valid/ready    cmd, now_ms, target_sensor, level_value, color_value
// res_out   source   valid/ready    duties, request_state, report fields
// cfg       write    cfg_we         cfg_index, cfg_data
//
// one beat per cycle unless res_out stalls; through input register, then result register
// the path between them is one 32-bit time compare and one 8x16 multiply per channel
// reset clears all settings to their defaults, no clearing pass
// a stalled res_out holds the result register; cmd_in keeps taking beats until the
// input register is also full
module rgb_led_fading_dimmer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rgbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbfd_pkg::CFG_DATA_W-1:0] cfg_data,
    rgbfd_cmd_if.sink                        cmd_in,
    rgbfd_res_if.source                      res_out
);

    // config
    logic [7:0]  own_sensor_reg;
    logic [9:0]  step_interval_reg;
    logic [15:0] init_timeout_reg;

    // input stage
    logic               s1_valid_reg;
    rgbfd_pkg::cmd_t    s1_cmd_reg;
    logic [31:0]        s1_now_reg;
    logic [7:0]         s1_sensor_reg;
    logic signed [15:0] s1_level_reg;
    logic [23:0]        s1_color_reg;

    // block state
    logic        lamp_on_reg, lamp_on_next;
    logic [6:0]  target_level_reg, target_level_next;
    logic [6:0]  bright_reg, bright_next;
    logic [23:0] color_reg, color_next;
    logic [31:0] next_step_reg, next_step_next;
    logic [2:0]  init_flags_reg, init_flags_next;
    logic        pending_reg, pending_next;
    logic [rgbfd_pkg::RECIP_W-1:0] recip_dn_reg, recip_dn_next;
    logic [rgbfd_pkg::RECIP_W-1:0] recip_cur_reg, recip_cur_next;
    logic [rgbfd_pkg::RECIP_W-1:0] recip_up_reg, recip_up_next;

    // result stage
    logic        out_valid_reg;
    logic [23:0] duty_reg;
    logic        req_reg, req_next;
    logic        vc_reg, vc_next;
    logic        von_reg, von_next;
    logic        vlev_reg, vlev_next;
    logic [23:0] rc_reg, rc_next;
    logic        ron_reg, ron_next;
    logic [6:0]  rlev_reg, rlev_next;

    logic        adv;
    logic        hit;
    logic [6:0]  clamp_level;
    logic        clamp_on;
    logic        step_en;
    logic [6:0]  goal;
    logic        step_up;
    logic        step_dn;
    logic [2:0]  flags_to;
    logic        pending_to;
    logic [rgbfd_pkg::RECIP_W-1:0] recip_sel;
    logic [23:0] color_sel;
    logic [23:0] duty_w;

    assign adv          = s1_valid_reg && (!out_valid_reg || res_out.ready);
    assign cmd_in.ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_sensor_reg    <= '0;
            step_interval_reg <= rgbfd_pkg::STEP_INTERVAL_RST;
            init_timeout_reg  <= rgbfd_pkg::INIT_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rgbfd_pkg::REG_OWN_SENSOR:    own_sensor_reg    <= cfg_data[7:0];
                rgbfd_pkg::REG_STEP_INTERVAL: step_interval_reg <= cfg_data[9:0];
                rgbfd_pkg::REG_INIT_TIMEOUT:  init_timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_in.ready)
        begin
            s1_valid_reg <= cmd_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.valid && cmd_in.ready)
        begin
            s1_cmd_reg    <= rgbfd_pkg::cmd_t'(cmd_in.cmd);
            s1_now_reg    <= cmd_in.now_ms;
            s1_sensor_reg <= cmd_in.target_sensor;
            s1_level_reg  <= cmd_in.level_value;
            s1_color_reg  <= cmd_in.color_value;
        end
    end

    // sensor match, level clamp, ramp decision and scale/color select
    always_comb
    begin
        hit = (s1_sensor_reg == own_sensor_reg);
        if (s1_level_reg > 16'sd100)
        begin
            clamp_level = rgbfd_pkg::LEVEL_MAX;
        end
        else if (s1_level_reg < 16'sd0)
        begin
            clamp_level = '0;
        end
        else
        begin
            clamp_level = s1_level_reg[6:0];
        end
        clamp_on = (clamp_level != '0);
        step_en  = (s1_cmd_reg == rgbfd_pkg::CMD_TICK) && (s1_now_reg >= next_step_reg);
        goal     = lamp_on_reg ? target_level_reg : '0;
        step_up  = step_en && (goal > bright_reg);
        step_dn  = step_en && (goal < bright_reg);
        recip_sel = step_up ? recip_up_reg : (step_dn ? recip_dn_reg : recip_cur_reg);
        color_sel = (s1_cmd_reg == rgbfd_pkg::CMD_COLOR && hit) ? s1_color_reg : color_reg;
    end

    rgbfd_scale u_scale (
        .color (color_sel),
        .recip (recip_sel),
        .duty  (duty_w)
    );

    always_comb
    begin
        lamp_on_next      = lamp_on_reg;
        target_level_next = target_level_reg;
        color_next        = color_reg;
        next_step_next    = next_step_reg;
        init_flags_next   = init_flags_reg;
        pending_next      = pending_reg;
        req_next          = 1'b0;
        vc_next           = 1'b0;
        von_next          = 1'b0;
        vlev_next         = 1'b0;
        rc_next           = '0;
        ron_next          = 1'b0;
        rlev_next         = '0;
        flags_to          = init_flags_reg;
        pending_to        = pending_reg;

        if (step_up)
        begin
            bright_next = bright_reg + 7'd1;
        end
        else if (step_dn)
        begin
            bright_next = bright_reg - 7'd1;
        end
        else
        begin
            bright_next = bright_reg;
        end

        case (s1_cmd_reg)
            rgbfd_pkg::CMD_TICK:
            begin
                req_next = (next_step_reg == '0);
                if (init_flags_reg != rgbfd_pkg::INIT_ALL &&
                    s1_now_reg > {16'd0, init_timeout_reg})
                begin
                    flags_to   = rgbfd_pkg::INIT_ALL;
                    pending_to = 1'b1;
                end
                init_flags_next = flags_to;
                if (pending_to)
                begin
                    if ((flags_to & rgbfd_pkg::INIT_COLOR) != '0)
                    begin
                        vc_next = 1'b1;
                        rc_next = color_reg;
                    end
                    if ((flags_to & rgbfd_pkg::INIT_ON) != '0)
                    begin
                        von_next = 1'b1;
                        ron_next = lamp_on_reg;
                    end
                    if ((flags_to & rgbfd_pkg::INIT_LEVEL) != '0)
                    begin
                        vlev_next = 1'b1;
                        rlev_next = target_level_reg;
                    end
                end
                pending_next = 1'b0;
                if (step_en)
                begin
                    next_step_next = s1_now_reg + {22'd0, step_interval_reg};
                end
            end
            rgbfd_pkg::CMD_ONOFF:
            begin
                if (hit)
                begin
                    lamp_on_next    = (s1_level_reg != 16'sd0);
                    init_flags_next = init_flags_reg | rgbfd_pkg::INIT_ON;
                    pending_next    = 1'b1;
                end
            end
            rgbfd_pkg::CMD_LEVEL:
            begin
                if (hit && (clamp_level != target_level_reg || clamp_on != lamp_on_reg))
                begin
                    target_level_next = clamp_on ? clamp_level : 7'd1;
                    lamp_on_next      = clamp_on;
                    init_flags_next   = init_flags_reg | rgbfd_pkg::INIT_LEVEL;
                    pending_next      = 1'b1;
                end
            end
            rgbfd_pkg::CMD_COLOR:
            begin
                if (hit)
                begin
                    color_next      = s1_color_reg;
                    init_flags_next = init_flags_reg | rgbfd_pkg::INIT_COLOR;
                    pending_next    = 1'b1;
                end
            end
            default: ;
        endcase

        recip_dn_next  = rgbfd_pkg::RECIP[bright_next - 7'd1];
        recip_cur_next = rgbfd_pkg::RECIP[bright_next];
        recip_up_next  = rgbfd_pkg::RECIP[bright_next + 7'd1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_on_reg      <= 1'b0;
            target_level_reg <= rgbfd_pkg::LEVEL_MAX;
            bright_reg       <= '0;
            color_reg        <= rgbfd_pkg::COLOR_WHITE;
            next_step_reg    <= '0;
            init_flags_reg   <= '0;
            pending_reg      <= 1'b0;
            recip_dn_reg     <= rgbfd_pkg::RECIP[rgbfd_pkg::RECIP_DEPTH-1];
            recip_cur_reg    <= rgbfd_pkg::RECIP[0];
            recip_up_reg     <= rgbfd_pkg::RECIP[1];
        end
        else if (adv)
        begin
            lamp_on_reg      <= lamp_on_next;
            target_level_reg <= target_level_next;
            bright_reg       <= bright_next;
            color_reg        <= color_next;
            next_step_reg    <= next_step_next;
            init_flags_reg   <= init_flags_next;
            pending_reg      <= pending_next;
            recip_dn_reg     <= recip_dn_next;
            recip_cur_reg    <= recip_cur_next;
            recip_up_reg     <= recip_up_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            duty_reg <= duty_w;
            req_reg  <= req_next;
            vc_reg   <= vc_next;
            von_reg  <= von_next;
            vlev_reg <= vlev_next;
            rc_reg   <= rc_next;
            ron_reg  <= ron_next;
            rlev_reg <= rlev_next;
        end
    end

    assign res_out.valid              = out_valid_reg;
    assign res_out.red_duty           = duty_reg[23:16];
    assign res_out.green_duty         = duty_reg[15:8];
    assign res_out.blue_duty          = duty_reg[7:0];
    assign res_out.request_state      = req_reg;
    assign res_out.report_color_valid = vc_reg;
    assign res_out.report_on_valid    = von_reg;
    assign res_out.report_level_valid = vlev_reg;
    assign res_out.report_color       = rc_reg;
    assign res_out.report_on          = ron_reg;
    assign res_out.report_level       = rlev_reg;

endmodule

// File: rtl/rgbfd_checker.sv
module rgbfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red_duty,
    input logic [7:0]  green_duty,
    input logic [7:0]  blue_duty,
    input logic        request_state,
    input logic        report_color_valid,
    input logic        report_on_valid,
    input logic        report_level_valid,
    input logic [23:0] report_color,
    input logic        report_on,
    input logic [6:0]  report_level
);

    // stalled result beat holds valid, duties, request_state and reported values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_duty) && $stable(green_duty)
            && $stable(blue_duty) && $stable(request_state) && $stable(report_color)
            && $stable(report_level) && $stable(report_on))
        else $error("stalled result beat changed");

    // nothing comes out right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    // a valid reported level is never zero and never above full scale, else it reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (report_level_valid ? (report_level != 7'd0 && report_level <= 7'd100)
                                          : (report_level == 7'd0)))
        else $error("bad reported level");

    // unreported settings read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (report_color_valid || report_color == 24'd0)
                   && (report_on_valid || !report_on))
        else $error("unreported setting not zero");

endmodule

bind rgb_led_fading_dimmer_top rgbfd_checker u_rgbfd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (res_out.valid),
    .out_ready          (res_out.ready),
    .red_duty           (res_out.red_duty),
    .green_duty         (res_out.green_duty),
    .blue_duty          (res_out.blue_duty),
    .request_state      (res_out.request_state),
    .report_color_valid (res_out.report_color_valid),
    .report_on_valid    (res_out.report_on_valid),
    .report_level_valid (res_out.report_level_valid),
    .report_color       (res_out.report_color),
    .report_on          (res_out.report_on),
    .report_level       (res_out.report_level)
);
